// ===== hw/rtl/json_string_escaper_utf8_defines.svh =====
// Assertion macros for the escaper's RTL.
// Both macros sample on the rising edge of clock and are off while reset is high.
`ifndef JSON_STRING_ESCAPER_UTF8_DEFINES_SVH
`define JSON_STRING_ESCAPER_UTF8_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JSE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("json escaper: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define JSE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("json escaper: next-cycle check failed");

`endif

// ===== hw/rtl/jse_pkg.sv =====
package jse_pkg;

   // Default number of entries in the command queue between front and back.
   localparam int QUEUE_DEPTH_DEF = 2;

   // Input byte codes that get special handling.
   localparam logic [7:0] BYTE_NUL   = 8'h00;
   localparam logic [7:0] BYTE_BS    = 8'h08;
   localparam logic [7:0] BYTE_TAB   = 8'h09;
   localparam logic [7:0] BYTE_LF    = 8'h0A;
   localparam logic [7:0] BYTE_FF    = 8'h0C;
   localparam logic [7:0] BYTE_CR    = 8'h0D;
   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] BYTE_ASCII = 8'h80;

   // Output characters.
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_D      = 8'h64;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;

   // Code point limits used by the UTF-8 check.
   localparam logic [20:0] CP_MIN2    = 21'h00080;
   localparam logic [20:0] CP_MIN3    = 21'h00800;
   localparam logic [20:0] CP_MIN4    = 21'h10000;
   localparam logic [20:0] CP_MAX     = 21'h10FFFF;
   localparam logic [20:0] CP_SURR_LO = 21'h0D800;
   localparam logic [20:0] CP_SURR_HI = 21'h0DFFF;

   // Kind of escape that closes a command.
   typedef enum logic [1:0] {
      TAIL_NONE = 2'd0,
      TAIL_ESC  = 2'd1,
      TAIL_UHEX = 2'd2
   } tail_type;

   // One command: opening quote, replacement escapes, literal bytes, closing escape.
   typedef struct packed {
      logic            quote;
      logic [2:0]      fffd_cnt;
      logic [2:0]      pass_cnt;
      logic [3:0][7:0] pass_bytes;
      tail_type        tail;
      logic [7:0]      tail_byte;
   } cmd_type;

   // Queue status seen by the front and back.
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // Lowercase hex digit for a nibble.
   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) begin
         return CH_ZERO + {4'h0, v};
      end
      return 8'h57 + {4'h0, v};
   endfunction

   // Character at a position of the replacement escape backslash-u-fffd.
   function automatic logic [7:0] fffd_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0: ch = CH_BSLASH;
         3'd1: ch = CH_U;
         3'd2: ch = CH_F;
         3'd3: ch = CH_F;
         3'd4: ch = CH_F;
         default: ch = CH_D;
      endcase
      return ch;
   endfunction

endpackage

// ===== hw/rtl/jse_front.sv =====
module jse_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // [7:0] in_byte
   input  jse_pkg::qstat_type q_stat,
   output logic               q_push,
   output jse_pkg::cmd_type   q_cmd
);
   import jse_pkg::*;

   logic       inside_ff, inside_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [2:0] len_ff, len_in;
   logic [7:0] held_ff [4];
   logic [7:0] held_in;
   logic [1:0] held_idx;
   logic       held_wr;
   logic       accept;
   logic       holding;
   logic [2:0] cnt_inc;
   logic [20:0] cp;
   logic [20:0] cp_min;
   logic       len_ok;
   logic       seq_ok;
   cmd_type    cmd;

   assign req_tready = !q_stat.full;
   assign accept     = req_tvalid && req_tready;

   // Code point of the sequence completed by the incoming byte.
   always_comb begin
      cp     = '0;
      cp_min = CP_MIN2;
      len_ok = 1'b1;
      case (len_ff)
         3'd2: begin
            cp     = {10'h0, held_ff[0][4:0], req_tdata[5:0]};
            cp_min = CP_MIN2;
         end
         3'd3: begin
            cp     = {5'h0, held_ff[0][3:0], held_ff[1][5:0], req_tdata[5:0]};
            cp_min = CP_MIN3;
         end
         3'd4: begin
            cp     = {held_ff[0][2:0], held_ff[1][5:0], held_ff[2][5:0], req_tdata[5:0]};
            cp_min = CP_MIN4;
         end
         default: len_ok = 1'b0;
      endcase
      seq_ok = len_ok && (cp >= cp_min) && (cp <= CP_MAX) &&
               !((cp >= CP_SURR_LO) && (cp <= CP_SURR_HI));
   end

   // Classify the byte and build the command for the back end.
   always_comb begin
      cmd       = '0;
      cmd.tail  = TAIL_NONE;
      inside_in = inside_ff;
      cnt_in    = cnt_ff;
      len_in    = len_ff;
      held_wr   = 1'b0;
      held_idx  = '0;
      held_in   = req_tdata;
      holding   = inside_ff && (cnt_ff != 3'd0);
      cnt_inc   = cnt_ff + 3'd1;
      cmd.quote = !inside_ff;

      if (holding && (req_tdata[7:6] == 2'b10)) begin
         // A follower byte of a held sequence.
         if (cnt_inc == len_ff) begin
            if (seq_ok) begin
               cmd.pass_cnt = len_ff;
               for (int k = 0; k < 4; k++) begin
                  cmd.pass_bytes[k] = (2'(k) == cnt_ff[1:0]) ? req_tdata : held_ff[k];
               end
            end else begin
               cmd.fffd_cnt = len_ff;
            end
            cnt_in = '0;
            len_in = '0;
         end else begin
            held_wr  = 1'b1;
            held_idx = cnt_ff[1:0];
            cnt_in   = cnt_inc;
         end
      end else begin
         // Any held bytes are replaced, then the byte is handled on its own.
         cmd.fffd_cnt = holding ? cnt_ff : 3'd0;
         cnt_in       = '0;
         len_in       = '0;
         inside_in    = 1'b1;
         case (req_tdata)
            BYTE_NUL: begin
               cmd.pass_cnt      = 3'd1;
               cmd.pass_bytes[0] = CH_QUOTE;
               inside_in         = 1'b0;
            end
            CH_QUOTE: begin
               cmd.tail      = TAIL_ESC;
               cmd.tail_byte = CH_QUOTE;
            end
            CH_BSLASH: begin
               cmd.tail      = TAIL_ESC;
               cmd.tail_byte = CH_BSLASH;
            end
            BYTE_BS: begin
               cmd.tail      = TAIL_ESC;
               cmd.tail_byte = CH_B;
            end
            BYTE_FF: begin
               cmd.tail      = TAIL_ESC;
               cmd.tail_byte = CH_F;
            end
            BYTE_LF: begin
               cmd.tail      = TAIL_ESC;
               cmd.tail_byte = CH_N;
            end
            BYTE_CR: begin
               cmd.tail      = TAIL_ESC;
               cmd.tail_byte = CH_R;
            end
            BYTE_TAB: begin
               cmd.tail      = TAIL_ESC;
               cmd.tail_byte = CH_T;
            end
            default: begin
               if (req_tdata < BYTE_SPACE) begin
                  cmd.tail      = TAIL_UHEX;
                  cmd.tail_byte = req_tdata;
               end else if (req_tdata < BYTE_ASCII) begin
                  cmd.pass_cnt      = 3'd1;
                  cmd.pass_bytes[0] = req_tdata;
               end else if (req_tdata[7:5] == 3'b110) begin
                  held_wr = 1'b1;
                  cnt_in  = 3'd1;
                  len_in  = 3'd2;
               end else if (req_tdata[7:4] == 4'b1110) begin
                  held_wr = 1'b1;
                  cnt_in  = 3'd1;
                  len_in  = 3'd3;
               end else if (req_tdata[7:3] == 5'b11110) begin
                  held_wr = 1'b1;
                  cnt_in  = 3'd1;
                  len_in  = 3'd4;
               end else begin
                  cmd.fffd_cnt = cmd.fffd_cnt + 3'd1;
               end
            end
         endcase
      end
   end

   // A command goes into the queue only if it produces output.
   assign q_cmd  = cmd;
   assign q_push = accept && (cmd.quote || (cmd.fffd_cnt != 3'd0) ||
                              (cmd.pass_cnt != 3'd0) || (cmd.tail != TAIL_NONE));

   // Hold state.
   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         cnt_ff    <= '0;
         len_ff    <= '0;
      end else if (accept) begin
         inside_ff <= inside_in;
         cnt_ff    <= cnt_in;
         len_ff    <= len_in;
      end
   end

   // Held sequence bytes.
   always_ff @(posedge clock) begin
      if (accept && held_wr) begin
         held_ff[held_idx] <= held_in;
      end
   end

endmodule

// ===== hw/rtl/jse_fifo.sv =====
module jse_fifo #(
   parameter int DEPTH = jse_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  jse_pkg::cmd_type   push_cmd,
   input  logic               pop,
   output jse_pkg::cmd_type   pop_cmd,
   output jse_pkg::qstat_type stat
);
   import jse_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         entries_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign pop_cmd    = entries_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == CW'(DEPTH));
   assign stat.empty = (count_ff == '0);

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10: count_in = count_ff + 1'b1;
         2'b01: count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/jse_back.sv =====
module jse_back (
   input  logic               clock,
   input  logic               reset,
   input  jse_pkg::qstat_type q_stat,
   input  jse_pkg::cmd_type   q_cmd,
   output logic               q_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,   // [7:0] out_byte
   output logic               rsp_tlast    // out_last
);
   import jse_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_QUOTE = 5'b00010,
      ST_FFFD  = 5'b00100,
      ST_PASS  = 5'b01000,
      ST_TAIL  = 5'b10000
   } bstate_type;

   // Where the search for the next phase starts.
   localparam logic [1:0] LV_START = 2'd0;
   localparam logic [1:0] LV_QUOTE = 2'd1;
   localparam logic [1:0] LV_FFFD  = 2'd2;
   localparam logic [1:0] LV_PASS  = 2'd3;

   // First phase of a command with output, at or after a given point.
   function automatic bstate_type phase_after(input cmd_type cmd, input logic [1:0] from);
      bstate_type st;
      if ((from == LV_START) && cmd.quote) begin
         st = ST_QUOTE;
      end else if ((from <= LV_QUOTE) && (cmd.fffd_cnt != 3'd0)) begin
         st = ST_FFFD;
      end else if ((from <= LV_FFFD) && (cmd.pass_cnt != 3'd0)) begin
         st = ST_PASS;
      end else if (cmd.tail != TAIL_NONE) begin
         st = ST_TAIL;
      end else begin
         st = ST_IDLE;
      end
      return st;
   endfunction

   bstate_type state_ff, state_in;
   logic [2:0] idx_ff, idx_in;
   logic [2:0] rep_ff, rep_in;
   cmd_type    cmd_ff, cmd_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       can_emit;
   logic       emit;
   logic       done;
   logic       last;
   logic       load;
   bstate_type nxt;
   logic [7:0] out_byte;

   assign can_emit = !rsp_valid_ff || rsp_tready;
   assign emit     = can_emit && (state_ff != ST_IDLE);

   // Byte of the current phase and whether the phase ends with it.
   always_comb begin
      out_byte = CH_QUOTE;
      done     = 1'b0;
      nxt      = ST_IDLE;
      case (state_ff)
         ST_QUOTE: begin
            out_byte = CH_QUOTE;
            done     = 1'b1;
            nxt      = phase_after(cmd_ff, LV_QUOTE);
         end
         ST_FFFD: begin
            out_byte = fffd_char(idx_ff);
            done     = (idx_ff == 3'd5) && (rep_ff == 3'd1);
            nxt      = phase_after(cmd_ff, LV_FFFD);
         end
         ST_PASS: begin
            out_byte = cmd_ff.pass_bytes[idx_ff[1:0]];
            done     = (idx_ff == (cmd_ff.pass_cnt - 3'd1));
            nxt      = phase_after(cmd_ff, LV_PASS);
         end
         ST_TAIL: begin
            if (cmd_ff.tail == TAIL_UHEX) begin
               case (idx_ff)
                  3'd0: out_byte = CH_BSLASH;
                  3'd1: out_byte = CH_U;
                  3'd2: out_byte = CH_ZERO;
                  3'd3: out_byte = CH_ZERO;
                  3'd4: out_byte = hex_char(cmd_ff.tail_byte[7:4]);
                  default: out_byte = hex_char(cmd_ff.tail_byte[3:0]);
               endcase
               done = (idx_ff == 3'd5);
            end else begin
               out_byte = (idx_ff == 3'd0) ? CH_BSLASH : cmd_ff.tail_byte;
               done     = (idx_ff == 3'd1);
            end
            nxt = ST_IDLE;
         end
         default: begin
            out_byte = CH_QUOTE;
            done     = 1'b0;
            nxt      = ST_IDLE;
         end
      endcase
      last = done && (nxt == ST_IDLE);
   end

   // Sequencer: step through the phases and fetch the next command.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      rep_in   = rep_ff;
      cmd_in   = cmd_ff;
      if (emit) begin
         if (done) begin
            state_in = nxt;
            idx_in   = '0;
         end else if ((state_ff == ST_FFFD) && (idx_ff == 3'd5)) begin
            idx_in = '0;
            rep_in = rep_ff - 3'd1;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
      load = !q_stat.empty && ((state_ff == ST_IDLE) || (emit && last));
      if (load) begin
         cmd_in   = q_cmd;
         state_in = phase_after(q_cmd, LV_START);
         idx_in   = '0;
         rep_in   = q_cmd.fffd_cnt;
      end
   end

   assign q_pop = load;

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (can_emit) begin
         rsp_valid_in = emit;
         rsp_data_in  = out_byte;
         rsp_last_in  = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rep_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rep_ff       <= rep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hw/rtl/json_string_escaper_utf8.sv =====
// Channel   Direction  Ports                    Content
// req       in         req_tvalid/tready/tdata  tdata[7:0] in_byte
// rsp       out        rsp_tvalid/tready/tdata  tdata[7:0] out_byte, tlast out_last
//
// The front end takes one input byte per cycle while the command queue has room.
// The back end sends one output byte per cycle while rsp_tready does not stall it;
// a byte that only starts a held UTF-8 sequence produces no output of its own, only
// the opening quote when it is the first byte of a string.
// Reset is synchronous and clears the string, hold, queue and output state.
// Either side may stall at any time; the queue and output register decouple them.
`include "json_string_escaper_utf8_defines.svh"

module json_string_escaper_utf8 #(
   parameter int QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast    // out_last
);
   import jse_pkg::*;

   qstat_type q_stat;
   cmd_type   push_cmd;
   cmd_type   pop_cmd;
   logic      q_push;
   logic      q_pop;

   // Front end: hold state and byte classification.
   jse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_stat     (q_stat),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   // Command queue between the two ends.
   jse_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .stat     (q_stat)
   );

   // Back end: expands commands into output bytes.
   jse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .q_cmd      (pop_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // The queue is never written when full nor read when empty.
   `JSE_ASSERT_NOW(a_no_overflow, q_push, !q_stat.full)
   `JSE_ASSERT_NOW(a_no_underflow, q_pop, !q_stat.empty)
   // A write without a read leaves at least one command waiting.
   `JSE_ASSERT_NEXT(a_push_fills, q_push && !q_pop, !q_stat.empty)

endmodule
